// ----- rtl/core/lz4d_pkg.sv -----
`default_nettype none
package lz4d_pkg;
    localparam int WindowBytesDefault = 65536;
    localparam logic [23:0] CapacityReset = 24'd65536;

    typedef enum logic [2:0] {
        PH_TOKEN  = 3'd0,
        PH_LITEXT = 3'd1,
        PH_LIT    = 3'd2,
        PH_OFF0   = 3'd3,
        PH_OFF1   = 3'd4,
        PH_MEXT   = 3'd5,
        PH_COPY   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_BADOFF   = 3'd3,
        ST_BUSY     = 3'd4
    } status_t;

    // One command from the parser to the output stage.
    typedef struct packed {
        logic        emit;      // produces a result item
        logic        from_hist; // byte comes from history read
        logic        wr;        // byte goes into history
        logic [15:0] wr_addr;
        logic [7:0]  lit;
        logic        data_valid;
        logic        done;
        status_t     status;
        logic [23:0] total;
    } cmd_t;
endpackage
`default_nettype wire

// ----- rtl/core/lz4d_ram.sv -----
`default_nettype none
module lz4d_ram #(
    parameter int Width = 8,
    parameter int Depth = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]              rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/lz4d_parser.sv -----
`default_nettype none
module lz4d_parser
    import lz4d_pkg::*;
#(
    parameter int WINDOW_BYTES = WindowBytesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        op,
    input  wire logic [7:0]  in_byte,
    input  wire logic        is_last,
    input  wire logic [23:0] capacity,
    output cmd_t             cmd,
    output logic [15:0]      rd_addr
);
    localparam int AW = $clog2(WINDOW_BYTES);

    phase_t      phase_reg, phase_next;
    logic [23:0] lit_reg, lit_next;
    logic [23:0] copy_reg, copy_next;
    logic [3:0]  mnib_reg, mnib_next;
    logic [15:0] dist_reg, dist_next;
    logic [23:0] prod_reg, prod_next;
    logic        end_reg, end_next;

    logic [25:0] want;
    logic        too_big;
    logic [16:0] dist_full;
    logic [AW-1:0] src;
    logic        clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOKEN;
            lit_reg   <= '0;
            copy_reg  <= '0;
            mnib_reg  <= '0;
            dist_reg  <= '0;
            prod_reg  <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            copy_reg  <= copy_next;
            mnib_reg  <= mnib_next;
            dist_reg  <= dist_next;
            prod_reg  <= prod_next;
            end_reg   <= end_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        lit_next   = lit_reg;
        copy_next  = copy_reg;
        mnib_next  = mnib_reg;
        dist_next  = dist_reg;
        prod_next  = prod_reg;
        end_next   = end_reg;
        clear      = 1'b0;
        cmd        = '0;
        cmd.status = ST_OK;
        cmd.wr_addr = 16'(prod_reg[AW-1:0]);
        cmd.lit    = in_byte;
        dist_full  = {1'b0, in_byte, dist_reg[7:0]};
        src        = AW'(prod_reg[AW-1:0] - dist_reg[AW-1:0]);
        rd_addr    = 16'(src);
        want       = '0;
        // only one count is checked per byte
        unique case (phase_reg)
            PH_TOKEN:  want = 26'(in_byte[7:4]);
            PH_LITEXT: want = 26'(lit_reg) + 26'(in_byte);
            PH_OFF1:   want = 26'(mnib_reg) + 26'd4;
            PH_MEXT:   want = 26'(copy_reg) + 26'(in_byte);
            default:   want = '0;
        endcase
        too_big = (26'(prod_reg) + want) > 26'(capacity);

        if (in_valid && op)
        begin
            if (phase_reg == PH_COPY && copy_reg != 0)
            begin
                cmd.emit = 1'b1;
                cmd.from_hist = 1'b1;
                cmd.wr = 1'b1;
                cmd.data_valid = 1'b1;
                prod_next = prod_reg + 24'd1;
                copy_next = copy_reg - 24'd1;
                if (copy_reg == 24'd1)
                begin
                    phase_next = PH_TOKEN;
                    if (end_reg)
                    begin
                        cmd.done  = 1'b1;
                        cmd.total = prod_reg + 24'd1;
                        clear = 1'b1;
                    end
                end
            end
        end
        else if (in_valid)
        begin
            unique case (phase_reg)
                PH_COPY:
                begin
                    cmd.emit = 1'b1;
                    cmd.status = ST_BUSY;
                end
                PH_TOKEN:
                begin
                    mnib_next = in_byte[3:0];
                    if (too_big)
                    begin
                        cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_OVERFLOW;
                        clear = 1'b1;
                    end
                    else
                    begin
                        lit_next = 24'(in_byte[7:4]);
                        if (in_byte[7:4] == 4'hF)       phase_next = PH_LITEXT;
                        else if (in_byte[7:4] == 4'h0)  phase_next = PH_OFF0;
                        else                            phase_next = PH_LIT;
                        if (is_last)
                        begin
                            cmd.emit = 1'b1; cmd.done = 1'b1; clear = 1'b1;
                            cmd.status = (in_byte[7:4] == 4'h0) ? ST_OK : ST_TRUNC;
                            cmd.total = (in_byte[7:4] == 4'h0) ? prod_reg : '0;
                        end
                    end
                end
                PH_LITEXT:
                begin
                    if (too_big)
                    begin
                        cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_OVERFLOW;
                        clear = 1'b1;
                    end
                    else
                    begin
                        lit_next = want[23:0];
                        if (in_byte != 8'hFF) phase_next = PH_LIT;
                        if (is_last)
                        begin
                            cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_TRUNC;
                            clear = 1'b1;
                        end
                    end
                end
                PH_LIT:
                begin
                    if (is_last && lit_reg > 24'd1)
                    begin
                        cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_TRUNC;
                        clear = 1'b1;
                    end
                    else
                    begin
                        cmd.emit = 1'b1; cmd.wr = 1'b1; cmd.data_valid = 1'b1;
                        prod_next = prod_reg + 24'd1;
                        if (lit_reg != 0) lit_next = lit_reg - 24'd1;
                        if (lit_reg <= 24'd1)
                        begin
                            phase_next = PH_OFF0;
                            if (is_last)
                            begin
                                cmd.done = 1'b1;
                                cmd.total = prod_reg + 24'd1;
                                clear = 1'b1;
                            end
                        end
                    end
                end
                PH_OFF0:
                begin
                    dist_next = 16'(in_byte);
                    phase_next = PH_OFF1;
                    if (is_last)
                    begin
                        cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_TRUNC;
                        clear = 1'b1;
                    end
                end
                PH_OFF1:
                begin
                    dist_next = dist_full[15:0];
                    if (dist_full == 0 || 24'(dist_full) > prod_reg
                        || dist_full > 17'(WINDOW_BYTES))
                    begin
                        cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_BADOFF;
                        clear = 1'b1;
                    end
                    else if (too_big)
                    begin
                        cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_OVERFLOW;
                        clear = 1'b1;
                    end
                    else
                    begin
                        copy_next = want[23:0];
                        if (mnib_reg == 4'hF)
                        begin
                            phase_next = PH_MEXT;
                            if (is_last)
                            begin
                                cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_TRUNC;
                                clear = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_COPY;
                            end_next = is_last;
                        end
                    end
                end
                PH_MEXT:
                begin
                    if (too_big)
                    begin
                        cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_OVERFLOW;
                        clear = 1'b1;
                    end
                    else
                    begin
                        copy_next = want[23:0];
                        if (in_byte == 8'hFF)
                        begin
                            if (is_last)
                            begin
                                cmd.emit = 1'b1; cmd.done = 1'b1; cmd.status = ST_TRUNC;
                                clear = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_COPY;
                            end_next = is_last;
                        end
                    end
                end
                default: clear = 1'b1;
            endcase
        end
        if (clear)
        begin
            phase_next = PH_TOKEN;
            lit_next = '0; copy_next = '0; mnib_next = '0;
            dist_next = '0; prod_next = '0; end_next = 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/lz4d_outq.sv -----
`default_nettype none
module lz4d_outq
    import lz4d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire cmd_t        cmd_in,
    input  wire logic [7:0]  hist_byte,
    input  wire logic [15:0] rd_addr,
    output logic             hist_we,
    output logic [15:0]      hist_waddr,
    output logic [7:0]       hist_wdata,
    output logic             full,
    input  wire logic        pop,
    output logic             empty,
    output logic             data_valid,
    output logic [7:0]       data_byte,
    output logic             block_done,
    output logic [2:0]       status,
    output logic [23:0]      total_length
);
    // stage 1 waits for the RAM read and writes the byte into history;
    // then a 4-entry queue
    localparam int Depth = 4;
    logic        s1_reg;
    cmd_t        c1_reg;
    cmd_t        q_reg [Depth];
    logic [7:0]  qb_reg [Depth];
    logic [1:0]  rp_reg, wp_reg;
    logic [2:0]  cnt_reg, cnt_next;
    logic        push_q, do_pop;
    logic [7:0]  b1;
    logic        fwd_reg;
    logic [7:0]  fwd_byte_reg;
    logic [7:0]  hist_eff;

    // a read of the address written at the same edge sees the old byte,
    // so that byte is carried over (distance-1 copies)
    assign hist_eff = fwd_reg ? fwd_byte_reg : hist_byte;
    assign b1 = c1_reg.from_hist ? hist_eff : c1_reg.lit;
    assign hist_we = s1_reg && c1_reg.wr;
    assign hist_waddr = c1_reg.wr_addr;
    assign hist_wdata = b1;
    assign push_q = s1_reg;
    assign empty = (cnt_reg == 3'd0);
    assign do_pop = pop && !empty;
    // one slot kept for the item in stage 1 and one for the incoming item
    assign full = (cnt_reg + 3'(s1_reg)) >= 3'(Depth - 1);
    assign cnt_next = cnt_reg + 3'(push_q) - 3'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= 1'b0;
            rp_reg  <= '0;
            wp_reg  <= '0;
            cnt_reg <= '0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            s1_reg  <= in_valid && cmd_in.emit;
            cnt_reg <= cnt_next;
            fwd_reg <= hist_we && (c1_reg.wr_addr == rd_addr);
            if (push_q) wp_reg <= wp_reg + 2'd1;
            if (do_pop) rp_reg <= rp_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg <= cmd_in;
        fwd_byte_reg <= b1;
        if (push_q)
        begin
            q_reg[wp_reg]  <= c1_reg;
            qb_reg[wp_reg] <= c1_reg.data_valid ? b1 : 8'd0;
        end
    end

    assign data_valid   = q_reg[rp_reg].data_valid;
    assign data_byte    = qb_reg[rp_reg];
    assign block_done   = q_reg[rp_reg].done;
    assign status       = q_reg[rp_reg].status;
    assign total_length = q_reg[rp_reg].total;
endmodule
`default_nettype wire

// ----- rtl/core/lz4_block_decompressor_core.sv -----
`default_nettype none
// LZ4 block decompressor. One item per cycle while full is low: push a compressed byte
// (op=0) or a tick (op=1) that emits one pending match byte. A front parser
// tracks the token/length/offset phases and checks capacity, truncation and
// offsets in the cycle the item is accepted; a back stage takes the history
// RAM read (one registered read per cycle), writes the output byte back into
// history in the cycle after acceptance (a distance-1 copy gets that byte
// forwarded) and places the result item into a small output queue, so
// results pop independently of input. A result becomes visible after stage 1
// and the queue write; sustained rate is one item per cycle while pop keeps up.
// History is a WINDOW_BYTES single-write, single-read RAM; no clearing pass
// is needed since offsets never reach unwritten bytes. out_capacity sits at
// address 0 of the APB port.
module lz4_block_decompressor_core
    import lz4d_pkg::*;
#(
    parameter int WINDOW_BYTES = WindowBytesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic        op,
    input  wire logic [7:0]  in_byte,
    input  wire logic        is_last,
    input  wire logic        pop,
    output logic             empty,
    output logic             data_valid,
    output logic [7:0]       data_byte,
    output logic             block_done,
    output logic [2:0]       status,
    output logic [23:0]      total_length
);
    localparam int AW = $clog2(WINDOW_BYTES);

    logic [23:0] cap_reg;
    logic        acc;
    cmd_t        cmd;
    logic [15:0] rd_addr;
    logic [7:0]  hist_byte;
    logic        hist_we;
    logic [15:0] hist_waddr;
    logic [7:0]  hist_wdata;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {8'd0, cap_reg} : 32'd0;
    assign acc = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CapacityReset;
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            cap_reg <= pwdata[23:0];
        end
    end

    lz4d_parser #(.WINDOW_BYTES(WINDOW_BYTES)) u_parser (
        .clk, .rst_n, .in_valid(acc), .op, .in_byte, .is_last,
        .capacity(cap_reg), .cmd, .rd_addr
    );

    lz4d_ram #(.Width(8), .Depth(WINDOW_BYTES)) u_hist (
        .clk,
        .we(hist_we),
        .waddr(hist_waddr[AW-1:0]),
        .wdata(hist_wdata),
        .re(1'b1),
        .raddr(rd_addr[AW-1:0]),
        .rdata(hist_byte)
    );

    lz4d_outq u_outq (
        .clk, .rst_n, .in_valid(acc), .cmd_in(cmd), .hist_byte, .rd_addr,
        .hist_we, .hist_waddr, .hist_wdata, .full, .pop, .empty,
        .data_valid, .data_byte, .block_done, .status, .total_length
    );
endmodule
`default_nettype wire

// ----- rtl/core/lz4d_checker.sv -----
`default_nettype none
module lz4d_checker
    import lz4d_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pop,
    input wire logic        empty,
    input wire logic        data_valid,
    input wire logic [7:0]  data_byte,
    input wire logic        block_done,
    input wire logic [2:0]  status,
    input wire logic [23:0] total_length
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status)) else $error("result dropped");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !data_valid |-> data_byte == 8'd0) else $error("stray byte");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !(block_done && status == ST_OK) |-> total_length == 24'd0)
        else $error("stray length");
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> status <= ST_BUSY) else $error("bad status");
endmodule

bind lz4_block_decompressor_core lz4d_checker u_chk (
    .clk, .rst_n, .pop, .empty, .data_valid, .data_byte, .block_done, .status,
    .total_length
);
`default_nettype wire

// ----- test/tb_lz4_block_decompressor_core.sv -----
`default_nettype none
module tb_lz4_block_decompressor_core;
    import lz4d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = 65536;
    localparam int DRAIN_CYCLES = 8;   // pipeline latency plus queue slack

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite, paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push, full, op, is_last, pop, empty;
    logic [7:0]  in_byte;
    logic        data_valid, block_done;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [23:0] total_length;

    lz4_block_decompressor_core u_top (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .push, .full, .op, .in_byte, .is_last, .pop, .empty,
        .data_valid, .data_byte, .block_done, .status, .total_length
    );

    // one decompressor output item
    typedef struct packed {
        logic        valid;
        logic [7:0]  dbyte;
        logic        done;
        logic [2:0]  st;
        logic [23:0] total;
    } out_item_t;

    out_item_t   pending_out[$];
    int          errors;
    int          items_sent;
    bit          calm;        // no idling on either side
    bit          hold_req;    // receiver holds off for a long stretch

    // decompressor shadow state
    logic [7:0]  hist [WIN];
    phase_t      dp_phase;
    int unsigned dp_lit_left, dp_copy_left, dp_mnib, dp_dist, dp_produced;
    bit          dp_ended;
    int unsigned dp_cap;
    bit          blk_over;    // last accepted item closed the block

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("tb_lz4_block_decompressor_core failed");
        $finish;
    end

    function automatic void clear_block();
        dp_phase = PH_TOKEN;
        dp_lit_left = 0;
        dp_copy_left = 0;
        dp_mnib = 0;
        dp_dist = 0;
        dp_produced = 0;
        dp_ended = 0;
    endfunction

    function automatic void emit(bit v, logic [7:0] b, bit d, status_t s);
        out_item_t e;
        e.valid = v;
        e.dbyte = v ? b : 8'd0;
        e.done  = d;
        e.st    = s;
        e.total = (d && s == ST_OK) ? dp_produced[23:0] : 24'd0;
        pending_out.push_back(e);
        if (d)
        begin
            blk_over = 1;
            clear_block();
        end
    endfunction

    function automatic bit over_cap(int unsigned n);
        return longint'(dp_produced) + longint'(n) > longint'(dp_cap);
    endfunction

    function automatic void hist_put(logic [7:0] b);
        hist[dp_produced % WIN] = b;
        dp_produced = (dp_produced + 1) & 24'hFFFFFF;
    endfunction

    // advance shadow state by one accepted item
    function automatic void decode_item(bit o, logic [7:0] b, bit l);
        int unsigned n;
        logic [7:0]  v;
        if (o)
        begin
            if (dp_phase != PH_COPY || dp_copy_left == 0)
                return;
            v = hist[(dp_produced + WIN - dp_dist) % WIN];
            hist_put(v);
            dp_copy_left--;
            if (dp_copy_left == 0)
            begin
                if (dp_ended)
                begin
                    emit(1, v, 1, ST_OK);
                    return;
                end
                dp_phase = PH_TOKEN;
            end
            emit(1, v, 0, ST_OK);
            return;
        end
        case (dp_phase)
            PH_COPY: emit(0, 0, 0, ST_BUSY);
            PH_TOKEN:
            begin
                n = b[7:4];
                dp_mnib = b[3:0];
                if (over_cap(n))
                    emit(0, 0, 1, ST_OVERFLOW);
                else
                begin
                    dp_lit_left = n;
                    dp_phase = (n == 15) ? PH_LITEXT : (n == 0) ? PH_OFF0 : PH_LIT;
                    if (l)
                        emit(0, 0, 1, n == 0 ? ST_OK : ST_TRUNC);
                end
            end
            PH_LITEXT:
            begin
                n = dp_lit_left + b;
                if (over_cap(n))
                    emit(0, 0, 1, ST_OVERFLOW);
                else
                begin
                    dp_lit_left = n;
                    if (b != 8'd255)
                        dp_phase = PH_LIT;
                    if (l)
                        emit(0, 0, 1, ST_TRUNC);
                end
            end
            PH_LIT:
            begin
                if (l && dp_lit_left > 1)
                    emit(0, 0, 1, ST_TRUNC);
                else
                begin
                    hist_put(b);
                    if (dp_lit_left > 0)
                        dp_lit_left--;
                    if (dp_lit_left == 0 && l)
                        emit(1, b, 1, ST_OK);
                    else
                    begin
                        if (dp_lit_left == 0)
                            dp_phase = PH_OFF0;
                        emit(1, b, 0, ST_OK);
                    end
                end
            end
            PH_OFF0:
            begin
                dp_dist = b;
                dp_phase = PH_OFF1;
                if (l)
                    emit(0, 0, 1, ST_TRUNC);
            end
            PH_OFF1:
            begin
                dp_dist = dp_dist | (int'(b) << 8);
                n = dp_mnib + 4;
                if (dp_dist == 0 || dp_dist > dp_produced || dp_dist > WIN)
                    emit(0, 0, 1, ST_BADOFF);
                else if (over_cap(n))
                    emit(0, 0, 1, ST_OVERFLOW);
                else
                begin
                    dp_copy_left = n;
                    if (dp_mnib == 15)
                    begin
                        dp_phase = PH_MEXT;
                        if (l)
                            emit(0, 0, 1, ST_TRUNC);
                    end
                    else
                    begin
                        dp_phase = PH_COPY;
                        dp_ended = l;
                    end
                end
            end
            PH_MEXT:
            begin
                n = dp_copy_left + b;
                if (over_cap(n))
                    emit(0, 0, 1, ST_OVERFLOW);
                else
                begin
                    dp_copy_left = n;
                    if (b == 8'd255)
                    begin
                        if (l)
                            emit(0, 0, 1, ST_TRUNC);
                    end
                    else
                    begin
                        dp_phase = PH_COPY;
                        dp_ended = l;
                    end
                end
            end
            default: clear_block();
        endcase
    endfunction

    // result checker: compares every popped item with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && pop && !empty)
        begin
            if (pending_out.size() == 0)
            begin
                $display("%0t: unexpected item valid=%0d byte=%02h done=%0d status=%0d total=%0d",
                         $time, data_valid, data_byte, block_done, status, total_length);
                errors++;
            end
            else
            begin
                e = pending_out.pop_front();
                if (data_valid !== e.valid)
                begin
                    $display("%0t: data_valid exp %0d got %0d", $time, e.valid, data_valid);
                    errors++;
                end
                if (data_byte !== e.dbyte)
                begin
                    $display("%0t: data_byte exp %02h got %02h", $time, e.dbyte, data_byte);
                    errors++;
                end
                if (block_done !== e.done)
                begin
                    $display("%0t: block_done exp %0d got %0d", $time, e.done, block_done);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, status);
                    errors++;
                end
                if (total_length !== e.total)
                begin
                    $display("%0t: total_length exp %0d got %0d", $time, e.total, total_length);
                    errors++;
                end
            end
        end
    end

    // receiver: random pop, with a counted long hold-off on request
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop = 1'b0;
                repeat (300) @(negedge clk);
                hold_req = 0;
            end
            else
                pop = calm || ($urandom_range(99) >= 35);
        end
    end

    // sends one item; entered and left at a falling edge
    task automatic send_item(bit o, logic [7:0] b, bit l);
        if (!calm)
            while ($urandom_range(99) < 35)
            begin
                push = 1'b0;
                @(negedge clk);
            end
        op = o;
        in_byte = b;
        is_last = l;
        push = 1'b1;
        do @(posedge clk); while (full);
        decode_item(o, b, l);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        push = 1'b0;
        while (pending_out.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_capacity(int unsigned cap);
        wait_drain();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = 1'b0;
        pwdata = cap;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        dp_cap = cap & 24'hFFFFFF;
    endtask

    // compressed byte, with optional early end injected
    task automatic comp_byte(logic [7:0] b, bit l, bit trunc);
        send_item(0, b, l | (trunc && $urandom_range(24) == 0));
    endtask

    // ticks until the pending copy is done, with busy bytes mixed in
    task automatic run_copy();
        blk_over = 0;
        while (dp_phase == PH_COPY && !blk_over)
            if ($urandom_range(19) == 0)
                send_item(0, $urandom, $urandom_range(1));
            else
                send_item(1, $urandom, $urandom_range(1));
    endtask

    // one block with random content, sometimes with a bad offset
    task automatic gen_block(int nseq, int maxlit, bit trunc);
        int lit, mnib, mext, dist_val, rem;
        bit fin, endlit;
        blk_over = 0;
        for (int s = 0; s < nseq; s++)
        begin
            fin = (s == nseq - 1);
            endlit = fin && $urandom_range(1);
            lit = ($urandom_range(3) == 0) ? $urandom_range(maxlit) : $urandom_range(6);
            if (dp_produced == 0 && !endlit && lit == 0)
                lit = 1;
            mnib = $urandom_range(15);
            mext = (mnib == 15) ? $urandom_range(300) : 0;
            comp_byte({(lit >= 15) ? 4'd15 : 4'(lit), 4'(mnib)}, endlit && lit == 0, trunc);
            if (blk_over)
                return;
            if (lit >= 15)
            begin
                rem = lit - 15;
                while (rem >= 255 && !blk_over)
                begin
                    comp_byte(8'd255, 0, trunc);
                    rem -= 255;
                end
                if (blk_over)
                    return;
                comp_byte(8'(rem), 0, trunc);
            end
            for (int i = 0; i < lit && !blk_over; i++)
                comp_byte($urandom, endlit && i == lit - 1, trunc);
            if (blk_over || endlit)
                return;
            if ($urandom_range(11) == 0)
                dist_val = $urandom_range(1) ? 0 : dp_produced + 1;
            else
                dist_val = $urandom_range(1, (dp_produced > 65535) ? 65535 : dp_produced);
            comp_byte(dist_val[7:0], 0, trunc);
            if (blk_over)
                return;
            comp_byte(dist_val[15:8], fin && mnib != 15, trunc);
            if (blk_over)
                return;
            if (mnib == 15)
            begin
                rem = mext;
                while (rem >= 255 && !blk_over)
                begin
                    comp_byte(8'd255, 0, trunc);
                    rem -= 255;
                end
                if (blk_over)
                    return;
                comp_byte(8'(rem), fin, trunc);
            end
            run_copy();
            if (blk_over)
                return;
        end
    endtask

    // hand-picked corners: empty block, idle tick, overlap copy, errors
    task automatic test_directed();
        send_item(0, 8'h00, 1);                 // empty block ends ok
        send_item(1, 8'hFF, 1);                 // idle tick
        send_item(0, 8'h10, 0);                 // 1 literal, match 4
        send_item(0, 8'hA5, 0);
        send_item(0, 8'h01, 0);                 // distance 1: overlapping copy
        send_item(0, 8'h00, 0);
        send_item(0, 8'h5A, 0);                 // busy while copy pends
        send_item(1, 8'h00, 0);
        send_item(1, 8'h00, 0);
        send_item(1, 8'h00, 0);
        send_item(1, 8'h00, 0);
        send_item(0, 8'h00, 0);                 // token 0x00: zero distance
        send_item(0, 8'h00, 0);
        send_item(0, 8'h00, 1);                 // bad offset
        send_item(0, 8'h30, 1);                 // truncated at token
        send_item(0, 8'hF0, 0);                 // literal extension
        send_item(0, 8'h01, 1);                 // truncated in extension
        send_item(0, 8'h30, 0);
        send_item(0, 8'h11, 0);
        send_item(0, 8'h22, 1);                 // truncated: literal dropped
        send_item(0, 8'h10, 0);
        send_item(0, 8'h77, 0);
        send_item(0, 8'h01, 0);
        send_item(0, 8'h00, 1);                 // ends after match
        run_copy();
        wait_drain();
    endtask

    // capacity extremes: zero, tight, largest, and back to reset value
    task automatic test_capacity();
        set_capacity(0);
        gen_block(2, 4, 0);
        send_item(0, 8'h00, 1);
        set_capacity(24);
        repeat (8) gen_block(4, 20, 0);
        set_capacity(24'hFFFFFF);
        repeat (2) gen_block(3, 300, 0);
        set_capacity(32'hFF00_0000 | 24'd65536);   // upper bits ignored
        wait_drain();
    endtask

    // receiver stalls long while a big literal run keeps the sender busy
    task automatic test_backpressure();
        hold_req = 1;
        send_item(0, 8'hF4, 0);
        send_item(0, 8'd200, 0);
        for (int i = 0; i < 215; i++)
            send_item(0, $urandom, 0);
        send_item(0, 8'h01, 0);
        send_item(0, 8'h00, 1);
        run_copy();
        wait_drain();
    endtask

    task automatic test_random();
        int start_cnt;
        start_cnt = items_sent;
        while (items_sent < 1350 || items_sent - start_cnt < 300)
        begin
            calm = (items_sent - start_cnt < 200);   // opening stretch with no idling
            if ($urandom_range(9) == 0)
                send_item($urandom_range(1), $urandom, $urandom_range(1));  // noise
            else
                gen_block($urandom_range(1, 5), ($urandom_range(7) == 0) ? 280 : 20,
                          $urandom_range(9) == 0);
        end
        calm = 0;
        wait_drain();
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        calm = 0;
        hold_req = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = '0;
        push = 1'b0;
        op = 1'b0;
        in_byte = '0;
        is_last = 1'b0;
        dp_cap = CapacityReset;
        clear_block();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_capacity();
        test_backpressure();
        test_random();

        wait_drain();
        if (errors == 0)
            $display("tb_lz4_block_decompressor_core passed");
        else
            $display("tb_lz4_block_decompressor_core failed");
        $finish;
    end
endmodule
`default_nettype wire
